// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion shorthands, all clocked on clk and muted while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every rising clock edge.
`define ALE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define ALE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ALE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ale_pkg.sv -----
// ----------------------------------------------------------------------------
// ale_pkg
// Sizes, request codes and cell control structs of the array list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ale_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;

  localparam int MODE_W  = 3;
  localparam int INDEX_W = 7;
  localparam int COUNT_W = 7;
  localparam int SLOT_W  = $clog2(DEPTH);

  // scan reduction: groups of eight cells, then across the groups
  localparam int GRP_SIZE  = 8;
  localparam int GRP_OFF_W = $clog2(GRP_SIZE);
  localparam int GRP_CNT   = DEPTH / GRP_SIZE;
  localparam int GRP_IDX_W = $clog2(GRP_CNT);

  localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(DEPTH);

  localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SELECT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd4;

  // storage update, valid only at the edge a request is taken
  typedef struct packed {
    logic                   ins;
    logic                   rem;
    logic                   rep;
    logic [INDEX_W-1:0]     index;
    logic [DATA_WIDTH-1:0]  value;
  } ale_upd_t;

  // compare/select control, held for the whole request
  typedef struct packed {
    logic                   search;
    logic                   select;
    logic [COUNT_W-1:0]     target;
    logic [COUNT_W-1:0]     count;
    logic [DATA_WIDTH-1:0]  value;
  } ale_scan_t;

endpackage

`default_nettype wire

// ----- design/ale_req_if.sv -----
// ----------------------------------------------------------------------------
// ale_req_if
// Request channel: kind, list position and value, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ale_req_if import ale_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [MODE_W-1:0]      mode;
  logic [INDEX_W-1:0]     index;
  logic [DATA_WIDTH-1:0]  value;

  modport source (output valid, output mode, output index, output value, input ready);
  modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

`default_nettype wire

// ----- design/ale_resp_if.sv -----
// ----------------------------------------------------------------------------
// ale_resp_if
// Result channel: status, search position, read data and list occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

interface ale_resp_if import ale_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   ok;
  logic [INDEX_W-1:0]     position;
  logic [DATA_WIDTH-1:0]  read_value;
  logic [COUNT_W-1:0]     count;
  logic                   is_empty;
  logic                   is_full;

  modport source (output valid, output ok, output position, output read_value,
                  output count, output is_empty, output is_full, input ready);
  modport sink   (input valid, input ok, input position, input read_value,
                  input count, input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// ----- design/ale_cell.sv -----
// ----------------------------------------------------------------------------
// ale_cell
// One list entry: shifts with its neighbors, registers its match flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_cell import ale_pkg::*; (
  input  wire logic                   clk,
  input  wire logic [SLOT_W-1:0]      slot,
  input  wire ale_upd_t               upd,
  input  wire ale_scan_t              scan,
  input  wire logic [DATA_WIDTH-1:0]  left_data,
  input  wire logic [DATA_WIDTH-1:0]  right_data,
  output logic [DATA_WIDTH-1:0]       data,
  output logic                        hit,
  output logic [DATA_WIDTH-1:0]       word
);

  logic [COUNT_W-1:0] pos;
  logic               in_list;
  logic               picked;

  assign pos     = COUNT_W'(slot);
  assign in_list = pos < scan.count;
  assign picked  = scan.select && (pos == scan.target);

  always_ff @(posedge clk) begin
    if (upd.ins && (pos > upd.index)) begin
      data <= left_data;
    end else if ((upd.ins || upd.rep) && (pos == upd.index)) begin
      data <= upd.value;
    end else if (upd.rem && (pos >= upd.index)) begin
      data <= right_data;
    end
  end

  always_ff @(posedge clk) begin
    hit  <= (scan.search && in_list && (data == scan.value)) || picked;
    word <= picked ? data : '0;
  end

endmodule

`default_nettype wire

// ----- design/ale_scan.sv -----
// ----------------------------------------------------------------------------
// ale_scan
// Two-level first-hit and OR reduction over the cell flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_scan import ale_pkg::*; (
  input  wire logic                   clk,
  input  wire logic [DEPTH-1:0]       hit,
  input  wire logic [DATA_WIDTH-1:0]  word [DEPTH],
  output logic                        any,
  output logic [SLOT_W-1:0]           first,
  output logic [DATA_WIDTH-1:0]       rdata
);

  logic [GRP_CNT-1:0]    g_hit;
  logic [GRP_OFF_W-1:0]  g_off  [GRP_CNT];
  logic [DATA_WIDTH-1:0] g_word [GRP_CNT];

  // first level, registered per group
  for (genvar g = 0; g < GRP_CNT; g++) begin : g_grp
    logic                  hit_c;
    logic [GRP_OFF_W-1:0]  off_c;
    logic [DATA_WIDTH-1:0] word_c;

    always_comb begin
      hit_c  = 1'b0;
      off_c  = '0;
      word_c = '0;
      for (int k = GRP_SIZE - 1; k >= 0; k--) begin
        if (hit[g*GRP_SIZE + k]) begin
          hit_c = 1'b1;
          off_c = GRP_OFF_W'(k);
        end
        word_c = word_c | word[g*GRP_SIZE + k];
      end
    end

    always_ff @(posedge clk) begin
      g_hit[g]  <= hit_c;
      g_off[g]  <= off_c;
      g_word[g] <= word_c;
    end
  end

  // second level across groups
  always_comb begin
    any   = 1'b0;
    first = '0;
    rdata = '0;
    for (int g = GRP_CNT - 1; g >= 0; g--) begin
      if (g_hit[g]) begin
        any   = 1'b1;
        first = SLOT_W'({GRP_IDX_W'(g), g_off[g]});
      end
      rdata = rdata | g_word[g];
    end
  end

endmodule

`default_nettype wire

// ----- design/array_list_engine.sv -----
// ----------------------------------------------------------------------------
// array_list_engine
// Packed ordered list held in a chain of entry cells: insert, remove,
// search, select and replace, one result per request.
// ----------------------------------------------------------------------------
//
//  port        dir   handshake        carries
//  ----------  ----  ---------------  --------------------------------------
//  req         in    valid/ready      mode, index, value
//  resp        out   valid/ready      ok, position, read_value, count,
//                                     is_empty, is_full
//  cfg_wr_*    in    write enable     capacity_limit (7 bits)
//
//  The accept edge updates the cells; then each cell's compare is registered,
//  then the group reduction, and the final reduction loads the output
//  register. A new request is taken only once the previous one has loaded
//  its result, also while that result still waits; a stalled result holds
//  the engine in its last step.
//  rst is synchronous: count 0, limit 64, no result pending; cells unreset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module array_list_engine import ale_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  ale_req_if.sink             req,
  ale_resp_if.source          resp,
  input  wire logic           cfg_wr_en,
  input  wire logic [6:0]     cfg_wr_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_GROUP = 2'd2;
  localparam logic [1:0] ST_FINAL = 2'd3;

  logic [1:0]            state, state_next;
  logic [COUNT_W-1:0]    count, count_next;
  logic [COUNT_W-1:0]    limit;
  logic [COUNT_W-1:0]    cap;

  // request held for the scan
  logic [MODE_W-1:0]     req_mode;
  logic [INDEX_W-1:0]    req_idx;
  logic [DATA_WIDTH-1:0] req_val;
  logic                  req_ok;

  logic                  accept;
  logic                  ins_ok, rem_ok, rep_ok;
  logic                  load_out;

  ale_upd_t              upd;
  ale_scan_t             scan;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_word [DEPTH];
  logic [DEPTH-1:0]      cell_hit;

  logic                  any;
  logic [SLOT_W-1:0]     first;
  logic [DATA_WIDTH-1:0] rdata;

  logic                  res_ok;
  logic [INDEX_W-1:0]    res_pos;

  // ---- configuration -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= CAP_RESET;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  // limit in use: 0 reads as 1, anything past the list size as the size
  assign cap = (limit == '0) ? COUNT_W'(1) :
               (limit > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH) : limit;

  // ---- request side --------------------------------------------------------
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  assign ins_ok = (req.mode == MODE_INSERT) && (count < cap) && (req.index <= count);
  assign rem_ok = (req.mode == MODE_REMOVE)  && (req.index < count);
  assign rep_ok = (req.mode == MODE_REPLACE) && (req.index < count);

  always_comb begin
    upd.ins   = accept && ins_ok;
    upd.rem   = accept && rem_ok;
    upd.rep   = accept && rep_ok;
    upd.index = req.index;
    upd.value = req.value;
  end

  always_comb begin
    count_next = count;
    if (upd.ins) begin
      count_next = count + COUNT_W'(1);
    end else if (upd.rem) begin
      count_next = count - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode <= req.mode;
      req_idx  <= req.index;
      req_val  <= req.value;
      req_ok   <= ins_ok || rem_ok || rep_ok;
    end
  end

  // select past the end falls back to the last entry
  always_comb begin
    scan.search = (req_mode == MODE_SEARCH);
    scan.select = (req_mode == MODE_SELECT) && (count != '0);
    scan.target = (req_idx < count) ? req_idx : count - COUNT_W'(1);
    scan.count  = count;
    scan.value  = req_val;
  end

  // ---- cell chain ----------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d, right_d;

    if (i == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    ale_cell u_cell (
      .clk        (clk),
      .slot       (SLOT_W'(i)),
      .upd        (upd),
      .scan       (scan),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .hit        (cell_hit[i]),
      .word       (cell_word[i])
    );
  end

  ale_scan u_scan (
    .clk   (clk),
    .hit   (cell_hit),
    .word  (cell_word),
    .any   (any),
    .first (first),
    .rdata (rdata)
  );

  // ---- sequencer -----------------------------------------------------------
  assign load_out = (state == ST_FINAL) && (!resp.valid || resp.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept)   state_next = ST_SCAN;
      ST_SCAN:                state_next = ST_GROUP;
      ST_GROUP:               state_next = ST_FINAL;
      ST_FINAL: if (load_out) state_next = ST_IDLE;
      default:                state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // ---- result --------------------------------------------------------------
  always_comb begin
    case (req_mode)
      MODE_SEARCH, MODE_SELECT:                res_ok = any;
      MODE_INSERT, MODE_REMOVE, MODE_REPLACE:  res_ok = req_ok;
      default:                                 res_ok = 1'b0;
    endcase
  end

  assign res_pos = (req_mode != MODE_SEARCH) ? '0 :
                   any ? INDEX_W'(first) : INDEX_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      resp.valid <= 1'b0;
    end else if (load_out) begin
      resp.valid <= 1'b1;
    end else if (resp.ready) begin
      resp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      resp.ok         <= res_ok;
      resp.position   <= res_pos;
      resp.read_value <= rdata;
      resp.count      <= count;
      resp.is_empty   <= (count == '0);
      resp.is_full    <= (count >= cap);
    end
  end

  // ---- checks --------------------------------------------------------------
  `ALE_ASSERT(a_count_bound, count <= COUNT_W'(DEPTH), "list count past depth")
  `ALE_ASSERT_NXT(a_count_hold, state != ST_IDLE, $stable(count), "count moved mid-request")
  `ALE_ASSERT_NXT(a_ins_grow, upd.ins, count == $past(count) + COUNT_W'(1), "insert lost count")
  `ALE_ASSERT_NXT(a_rem_shrink, upd.rem, count == $past(count) - COUNT_W'(1), "remove lost count")
  `ALE_ASSERT_IMP(a_out_src, $rose(resp.valid), $past(state) == ST_FINAL, "result from no request")

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for array_list_engine. It starts with a table of
// requests that covers the empty list, the field extremes and the refused
// cases. After that come phases of random requests, each at one list
// capacity. Each result is checked against the list predictor or a typed row.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import ale_pkg::*; ();

  // --------------------------------------------------------------------------
  // Constants
  // --------------------------------------------------------------------------
  // request kinds the engine ignores: still answered, ok low, no state change
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES  = 200;    // long receiver back-off
  localparam int unsigned DRAIN_CYCLES = 20;     // margin past the result path
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned N_DIRECTED   = 22;
  localparam int unsigned N_PHASES     = 9;

  // one result, in port order
  typedef struct packed {
    logic                   ok;
    logic [INDEX_W-1:0]     position;
    logic [DATA_WIDTH-1:0]  read_value;
    logic [COUNT_W-1:0]     count;
    logic                   is_empty;
    logic                   is_full;
  } list_result_t;

  // one row of the directed table; want is used only when typed is set
  typedef struct packed {
    logic [MODE_W-1:0]      mode;
    logic [INDEX_W-1:0]     index;
    logic [DATA_WIDTH-1:0]  value;
    logic                   typed;
    list_result_t           want;
  } directed_row_t;

  // random phase: capacity, mix of inserts/removes, length, long back-off
  typedef struct {
    int unsigned cap;
    int unsigned ins_pct;
    int unsigned rem_pct;
    int unsigned n_items;
    bit          hold;
  } phase_t;

  // --------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // --------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic [6:0] cfg_wr_data;

  always #5 clk = ~clk;

  ale_req_if  req_ch ();
  ale_resp_if resp_ch ();

  array_list_engine i_dut (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .resp        (resp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // --------------------------------------------------------------------------
  // List predictor state
  // --------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] list_q [DEPTH];
  int unsigned           list_len;
  logic [6:0]            capacity_q;

  list_result_t awaited_results [$];

  // run statistics
  int unsigned n_requests;
  int unsigned n_results;
  int unsigned n_refused;
  int unsigned n_full_seen;
  int unsigned peak_len;
  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  int unsigned holdoff_reqs;   // bumped by the sender side, served by receiver

  // --------------------------------------------------------------------------
  // Directed table. Typed rows: empty list, refused requests, insert into an
  // empty list, then at the head. Other rows go through the predictor.
  // --------------------------------------------------------------------------
  directed_row_t directed_rows [N_DIRECTED] = '{
    // empty list: select gives 0, remove/replace/insert past count refused
    '{MODE_SELECT,  7'd0,   32'd0,          1'b1, '{1'b0, 7'd0, 32'd0, 7'd0, 1'b1, 1'b0}},
    '{MODE_REMOVE,  7'd0,   32'd0,          1'b1, '{1'b0, 7'd0, 32'd0, 7'd0, 1'b1, 1'b0}},
    '{MODE_SEARCH,  7'd0,   32'd0,          1'b1, '{1'b0, 7'd0, 32'd0, 7'd0, 1'b1, 1'b0}},
    '{MODE_REPLACE, 7'd0,   32'd5,          1'b1, '{1'b0, 7'd0, 32'd0, 7'd0, 1'b1, 1'b0}},
    '{MODE_INSERT,  7'd1,   32'd7,          1'b1, '{1'b0, 7'd0, 32'd0, 7'd0, 1'b1, 1'b0}},
    '{MODE_SPARE_C, 7'd127, 32'hFFFF_FFFF,  1'b1, '{1'b0, 7'd0, 32'd0, 7'd0, 1'b1, 1'b0}},
    // insert into the empty list, then at the head
    '{MODE_INSERT,  7'd0,   32'hFFFF_FFFF,  1'b1, '{1'b1, 7'd0, 32'd0, 7'd1, 1'b0, 1'b0}},
    '{MODE_INSERT,  7'd0,   32'd0,          1'b1, '{1'b1, 7'd0, 32'd0, 7'd2, 1'b0, 1'b0}},
    // append, replace at index 0, search hit and miss
    '{MODE_INSERT,  7'd2,   32'hA5A5_5A5A,  1'b0, '0},
    '{MODE_REPLACE, 7'd0,   32'h8000_0001,  1'b0, '0},
    '{MODE_SEARCH,  7'd0,   32'hFFFF_FFFF,  1'b0, '0},
    '{MODE_SEARCH,  7'd0,   32'h1234_5678,  1'b0, '0},
    // select past the end returns the last entry
    '{MODE_SELECT,  7'd127, 32'd0,          1'b0, '0},
    '{MODE_SELECT,  7'd64,  32'd0,          1'b0, '0},
    '{MODE_SELECT,  7'd1,   32'd0,          1'b0, '0},
    // remove/insert at or past the count
    '{MODE_REMOVE,  7'd3,   32'd0,          1'b0, '0},
    '{MODE_REMOVE,  7'd127, 32'd0,          1'b0, '0},
    '{MODE_INSERT,  7'd127, 32'h5555_AAAA,  1'b0, '0},
    '{MODE_SPARE_A, 7'd0,   32'd1,          1'b0, '0},
    '{MODE_SPARE_B, 7'd64,  32'd2,          1'b0, '0},
    '{MODE_REMOVE,  7'd0,   32'd0,          1'b0, '0},
    '{MODE_SELECT,  7'd0,   32'd0,          1'b0, '0}
  };

  // capacity 0 and 127 check the clamp; 3 and 2 after a fill leave the
  // count above the limit
  phase_t phases [N_PHASES] = '{
    '{1,   50, 20,  80, 1'b0},
    '{0,   50, 20,  60, 1'b0},
    '{127, 75,  5, 260, 1'b1},
    '{64,  55, 15, 150, 1'b0},
    '{3,   20, 45, 150, 1'b0},
    '{33,  55, 15, 200, 1'b0},
    '{2,   30, 30, 100, 1'b0},
    '{64,  70, 10, 200, 1'b1},
    '{50,  30, 40, 150, 1'b0}
  };

  // --------------------------------------------------------------------------
  // Predictor: applies one request to the bench list, returns its result
  // --------------------------------------------------------------------------
  function automatic list_result_t predict_list_op(logic [MODE_W-1:0] mode,
                                                   logic [INDEX_W-1:0] index,
                                                   logic [DATA_WIDTH-1:0] value);
    list_result_t r;
    int unsigned  cap;
    int unsigned  idx;
    int unsigned  i;
    bit           found;
    r     = '0;
    idx   = index;
    found = 1'b0;
    // limit in use is clamped to 1..DEPTH
    cap = (capacity_q == 0) ? 1 : ((capacity_q > DEPTH) ? DEPTH : capacity_q);
    case (mode)
      MODE_INSERT: begin
        if (list_len < cap && idx <= list_len) begin
          for (i = list_len; i > idx; i--) list_q[i] = list_q[i-1];
          list_q[idx] = value;
          list_len++;
          r.ok = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (idx < list_len) begin
          for (i = idx; i + 1 < list_len; i++) list_q[i] = list_q[i+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      MODE_SEARCH: begin
        // miss reports the count as the position
        r.position = INDEX_W'(list_len);
        for (i = 0; i < list_len; i++) begin
          if (!found && list_q[i] == value) begin
            found      = 1'b1;
            r.position = INDEX_W'(i);
            r.ok       = 1'b1;
          end
        end
      end
      MODE_SELECT: begin
        if (list_len > 0) begin
          r.read_value = (idx < list_len) ? list_q[idx] : list_q[list_len-1];
          r.ok         = 1'b1;
        end
      end
      MODE_REPLACE: begin
        if (idx < list_len) begin
          list_q[idx] = value;
          r.ok        = 1'b1;
        end
      end
      default: ;
    endcase
    r.count    = COUNT_W'(list_len);
    r.is_empty = (list_len == 0);
    r.is_full  = (list_len >= cap);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random request fields
  // --------------------------------------------------------------------------
  function automatic logic [MODE_W-1:0] pick_mode(int unsigned ins_pct,
                                                  int unsigned rem_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    // small share of ignored kinds as noise
    if (r < 3) return MODE_SPARE_A + MODE_W'(r);
    r = $urandom_range(0, 99);
    if (r < ins_pct)           return MODE_INSERT;
    if (r < ins_pct + rem_pct) return MODE_REMOVE;
    case ($urandom_range(0, 2))
      0:       return MODE_SEARCH;
      1:       return MODE_SELECT;
      default: return MODE_REPLACE;
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index(logic [MODE_W-1:0] mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return INDEX_W'($urandom_range(0, 127));   // full field range
    if (r < 17) return INDEX_W'(list_len);                 // right at the count
    if (mode == MODE_INSERT || list_len == 0) return INDEX_W'($urandom_range(0, list_len));
    return INDEX_W'($urandom_range(0, list_len - 1));
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    // reuse stored values and a small pool so searches hit, duplicates occur
    if (r < 30 && list_len > 0) return list_q[$urandom_range(0, list_len - 1)];
    if (r < 60) return DATA_WIDTH'($urandom_range(0, 7));
    if (r < 65) return '1;
    return $urandom;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offers one request, waits for the handshake, books the
  // expected result. Bursts of random length with random gaps in between.
  // --------------------------------------------------------------------------
  task automatic offer_request(input logic [MODE_W-1:0] mode,
                               input logic [INDEX_W-1:0] index,
                               input logic [DATA_WIDTH-1:0] value,
                               input logic typed,
                               input list_result_t want);
    list_result_t predicted;
    req_ch.valid <= 1'b1;
    req_ch.mode  <= mode;
    req_ch.index <= index;
    req_ch.value <= value;
    do @(posedge clk); while (!req_ch.ready);
    // accepted at this edge: update the bench list and book the result
    predicted = predict_list_op(mode, index, value);
    awaited_results.push_back(typed ? want : predicted);
    n_requests++;
    if (!predicted.ok) n_refused++;
    if (list_len > peak_len) peak_len = list_len;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // occasional long burst with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
    end
  endtask

  // drain all outstanding results, then write the capacity register
  task automatic set_capacity(input logic [6:0] cap);
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    capacity_q  = cap;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stalls on a pattern of its own. Each stretch picks a style
  // (always ready, mostly ready, mostly stalled, periodic). A back-off
  // request holds ready low for the whole receiver back-off so the engine fills up.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned style;
    int unsigned stretch;
    int unsigned holds_done;
    int unsigned tick;
    int unsigned k;
    resp_ch.ready <= 1'b0;
    holds_done = 0;
    tick       = 0;
    forever begin
      style   = $urandom_range(0, 3);
      stretch = $urandom_range(40, 300);
      repeat (stretch) begin
        @(posedge clk);
        tick++;
        if (holdoff_reqs != holds_done) begin
          resp_ch.ready <= 1'b0;
          for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
          holds_done++;
        end else begin
          case (style)
            0:       resp_ch.ready <= 1'b1;
            1:       resp_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       resp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: resp_ch.ready <= ((tick % 5) < 2);
          endcase
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each accepted result against the oldest expectation
  // --------------------------------------------------------------------------
  list_result_t got_result;
  list_result_t want_result;

  always @(posedge clk) begin
    if (!rst && resp_ch.valid && resp_ch.ready) begin
      got_result = '{resp_ch.ok, resp_ch.position, resp_ch.read_value,
                     resp_ch.count, resp_ch.is_empty, resp_ch.is_full};
      n_results++;
      if (got_result.is_full) n_full_seen++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0d] result with no request pending: ok %0b pos %0d rd %h count %0d",
                   cycle_cnt, got_result.ok, got_result.position,
                   got_result.read_value, got_result.count);
      end else begin
        want_result = awaited_results.pop_front();
        if (got_result !== want_result) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display({"[%0d] result %0d (exp/got): ok %0b/%0b pos %0d/%0d rd %h/%h ",
                      "count %0d/%0d empty %0b/%0b full %0b/%0b"},
                     cycle_cnt, n_results,
                     want_result.ok, got_result.ok,
                     want_result.position, got_result.position,
                     want_result.read_value, got_result.read_value,
                     want_result.count, got_result.count,
                     want_result.is_empty, got_result.is_empty,
                     want_result.is_full, got_result.is_full);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[%0d] timeout, %0d results still outstanding",
               cycle_cnt, awaited_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned          p;
    int unsigned          n;
    logic [MODE_W-1:0]    mode;
    logic [INDEX_W-1:0]   index;
    logic [DATA_WIDTH-1:0] value;

    // every DUT input known from time 0
    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    req_ch.valid <= 1'b0;
    req_ch.mode  <= '0;
    req_ch.index <= '0;
    req_ch.value <= '0;
    cycle_cnt    <= 0;
    holdoff_reqs <= 0;

    // bench list mirrors the reset state: empty, limit 64
    list_len    = 0;
    capacity_q  = CAP_RESET;
    n_requests  = 0;
    n_results   = 0;
    n_refused   = 0;
    n_full_seen = 0;
    peak_len    = 0;
    mismatches  = 0;
    burst_left  = $urandom_range(1, 24);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at the reset capacity
    for (n = 0; n < N_DIRECTED; n++)
      offer_request(directed_rows[n].mode, directed_rows[n].index,
                    directed_rows[n].value, directed_rows[n].typed,
                    directed_rows[n].want);

    // random phases, one capacity each; the register changes only while idle
    for (p = 0; p < N_PHASES; p++) begin
      set_capacity(7'(phases[p].cap));
      for (n = 0; n < phases[p].n_items; n++) begin
        // a third of the way in, ask the receiver for a long back-off
        if (phases[p].hold && n == phases[p].n_items / 3)
          holdoff_reqs <= holdoff_reqs + 1;
        mode  = pick_mode(phases[p].ins_pct, phases[p].rem_pct);
        index = pick_index(mode);
        value = pick_value();
        offer_request(mode, index, value, 1'b0, '0);
      end
    end

    // wait out the last results, then a margin past the latency
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d refused) over %0d capacity settings, %0d results checked",
             n_requests, n_refused, N_PHASES + 1, n_results);
    $display("List grew to %0d entries; %0d results reported a full list",
             peak_len, n_full_seen);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
